### rtl/isbp_pkg.sv
// ----------------------------------------------------------------------------
// isbp_pkg
// shared types and constants of the instruction stream buffer prefetcher
// ----------------------------------------------------------------------------
`default_nettype none

package isbp_pkg;

    localparam logic [1:0] MODE_FETCH = 2'd0;
    localparam logic [1:0] MODE_PROBE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [63:0] WORD_MASK = 64'hFFFF_FFFF_FFFF_FFFC;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_UPPER = 6'b000100,
        ST_RESP  = 6'b001000,
        ST_REQ   = 6'b010000,
        ST_WAIT  = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic fill;      // write fill word if it hits
        logic upper;     // capture upper-half lookup
        logic alloc;     // allocate stream at alloc_a
        logic free_s;    // free the hit stream
        logic req_step;  // advance request address
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic filled;
        logic odd;
        logic up_hit;
        logic up_filled;
        logic last_slot;
        logic next_cov;
    } t_stat;

endpackage

`default_nettype wire

### rtl/isbp_datapath.sv
// ----------------------------------------------------------------------------
// isbp_datapath
// stream tags, slot memory with filled bits, lookup and request addressing
// ----------------------------------------------------------------------------
`default_nettype none

module isbp_datapath #(
    parameter int DEPTH       = 16,
    parameter int NUM_STREAMS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire isbp_pkg::t_cmd     i_cmd,
    input  wire logic               i_alloc_sel, // 0 miss addr, 1 upper/next addr
    input  wire logic [1:0]         i_mode,
    input  wire logic [63:0]        i_addr,
    input  wire logic [31:0]        i_fill_word,
    output isbp_pkg::t_stat         o_stat,
    output logic [31:0]             o_inst,
    output logic [63:0]             o_req_addr
);
    import isbp_pkg::*;

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int OW = $clog2(DEPTH);
    localparam int NSLOT = NUM_STREAMS * DEPTH;
    localparam int AW = $clog2(NSLOT);
    localparam logic [63:0] WIN = 64'(DEPTH * 4);

    logic [63:0]            r_base [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] r_live;
    logic [NSLOT-1:0]       r_filled;
    logic [31:0]            r_mem [NSLOT];
    logic [SW-1:0]          r_rptr;

    logic [63:0]   r_a;       // item address, bit 0 cleared
    logic [SW-1:0] r_s;
    logic [OW-1:0] r_off;
    logic          r_hit, r_fl;
    logic          r_uhit, r_ufl;
    logic [31:0]   r_lo_word;
    logic [31:0]   r_hi_word;
    logic [63:0]   r_req;

    // shared window search
    function automatic logic [SW+OW:0] f_find(input logic [63:0] a,
            input logic [63:0] b [NUM_STREAMS], input logic [NUM_STREAMS-1:0] lv);
        logic [63:0] d;
        logic [SW+OW:0] res;
        res = '0;
        for (int s = NUM_STREAMS - 1; s >= 0; s--) begin
            d = a - b[s];
            if (lv[s] && d < WIN) res = {1'b1, SW'(s), d[OW+1:2]};
        end
        return res;
    endfunction

    logic [63:0]    a_in, ua;
    logic [SW+OW:0] f_main, f_up, f_nx;
    logic [63:0]    next_a;
    logic [AW-1:0]  idx_main, idx_up;
    logic [SW+OW:0] f_fill;
    logic [AW-1:0]  idx_fill;

    assign a_in   = {i_addr[63:1], 1'b0};
    assign ua     = r_a + 64'd2;
    assign next_a = r_base[r_s] + WIN;
    assign f_main = f_find(a_in, r_base, r_live);
    assign f_up   = f_find(ua, r_base, r_live);
    assign f_nx   = f_find(next_a, r_base, r_live);
    assign f_fill = f_find(i_addr, r_base, r_live);
    assign idx_main = AW'(f_main[SW+OW-1:OW]) * AW'(DEPTH) + AW'(f_main[OW-1:0]);
    assign idx_up   = AW'(f_up[SW+OW-1:OW]) * AW'(DEPTH) + AW'(f_up[OW-1:0]);
    assign idx_fill = AW'(f_fill[SW+OW-1:OW]) * AW'(DEPTH) + AW'(f_fill[OW-1:0]);

    // allocation target
    logic [SW-1:0] free_s;
    logic          any_free;
    always_comb begin
        free_s = '0;
        any_free = 1'b0;
        for (int t = NUM_STREAMS - 1; t >= 0; t--) begin
            if (!r_live[t]) begin
                free_s = SW'(t);
                any_free = 1'b1;
            end
        end
    end
    logic [SW-1:0] alloc_s;
    logic [63:0]   alloc_a;
    assign alloc_s = any_free ? free_s : r_rptr;
    assign alloc_a = i_alloc_sel ? (r_uhit ? next_a : ua) : r_a;

    logic [NSLOT-1:0] clr_mask;
    always_comb begin
        for (int k = 0; k < NSLOT; k++) clr_mask[k] = (k / DEPTH) == int'(alloc_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_filled <= '0;
            r_rptr   <= '0;
            for (int s = 0; s < NUM_STREAMS; s++) r_base[s] <= '0;
        end else begin
            if (i_cmd.fill && i_mode == MODE_FILL && f_fill[SW+OW])
                r_filled[idx_fill] <= 1'b1;
            if (i_cmd.free_s) r_live[r_s] <= 1'b0;
            if (i_cmd.alloc) begin
                r_base[alloc_s] <= alloc_a & WORD_MASK;
                r_live[alloc_s] <= 1'b1;
                r_filled <= r_filled & ~clr_mask;
                if (!any_free)
                    r_rptr <= (int'(r_rptr) == NUM_STREAMS - 1) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    // slot memory, one write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill && i_mode == MODE_FILL && f_fill[SW+OW])
            r_mem[idx_fill] <= i_fill_word;
        if (i_cmd.load) r_lo_word <= r_mem[idx_main];
        if (i_cmd.upper) r_hi_word <= r_mem[idx_up];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= a_in;
            r_hit <= f_main[SW+OW];
            r_s   <= f_main[SW+OW-1:OW];
            r_off <= f_main[OW-1:0];
            r_fl  <= f_main[SW+OW] && r_filled[idx_main];
        end
        if (i_cmd.upper) begin
            r_uhit <= f_up[SW+OW];
            r_ufl  <= f_up[SW+OW] && r_filled[idx_up];
        end else if (i_cmd.load) begin
            r_uhit <= 1'b0;
        end
        if (i_cmd.alloc) r_req <= alloc_a & WORD_MASK;
        else if (i_cmd.req_step) r_req <= r_req + 64'd4;
    end

    assign o_stat.hit       = r_hit;
    assign o_stat.filled    = r_fl;
    assign o_stat.odd       = r_a[1];
    assign o_stat.up_hit    = r_uhit;
    assign o_stat.up_filled = r_ufl;
    assign o_stat.last_slot = int'(r_off) == DEPTH - 1;
    assign o_stat.next_cov  = f_nx[SW+OW];
    assign o_inst     = r_a[1] ? {r_hi_word[15:0], r_lo_word[31:16]} : r_lo_word;
    assign o_req_addr = r_req;

endmodule

`default_nettype wire

### rtl/isbp_ctrl.sv
// ----------------------------------------------------------------------------
// isbp_ctrl
// sequencer: lookup, response, request burst, output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module isbp_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_mode,
    input  wire isbp_pkg::t_stat i_stat,
    output isbp_pkg::t_cmd      o_cmd,
    output logic                o_alloc_sel,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic                o_kind,
    output logic                o_fetched,
    output logic                o_last
);
    import isbp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic          r_consume, r_fetched, r_alloc, r_sel;
    logic [CW-1:0] r_cnt;
    logic          acc_in, out_ok;

    assign acc_in  = i_valid && r_state == ST_IDLE;
    assign o_stall = r_state != ST_IDLE;
    assign out_ok  = !i_stall;

    // decision once lookups are known
    logic d_fetched, d_alloc, d_sel;
    always_comb begin
        d_fetched = 1'b0; d_alloc = 1'b0; d_sel = 1'b0;
        if (!i_stat.hit) begin
            d_alloc = 1'b1;
        end else if (i_stat.filled) begin
            if (i_stat.odd && !i_stat.up_hit) begin
                d_alloc = 1'b1; d_sel = 1'b1;
            end else if (!i_stat.odd || i_stat.up_filled) begin
                d_fetched = 1'b1;
                if (r_consume && i_stat.last_slot) begin
                    d_alloc = !i_stat.next_cov;
                    d_sel = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_alloc_sel = r_sel;
        o_cmd.load = acc_in;
        o_cmd.fill = acc_in;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && (i_mode == MODE_FETCH || i_mode == MODE_PROBE))
                    n_state = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd.upper = 1'b1;
                n_state = ST_UPPER;
            end
            ST_UPPER: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_ok) begin
                    n_state = r_alloc ? ST_WAIT : ST_IDLE;
                    o_cmd.free_s = r_fetched && r_consume && i_stat.last_slot;
                end
            end
            ST_WAIT: begin
                // allocate after free so the freed stream may be reused
                o_cmd.alloc = 1'b1;
                n_state = ST_REQ;
            end
            ST_REQ: begin
                if (out_ok) begin
                    o_cmd.req_step = 1'b1;
                    if (int'(r_cnt) == DEPTH - 1) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_consume <= 1'b0; r_fetched <= 1'b0; r_alloc <= 1'b0; r_sel <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_in) r_consume <= i_mode == MODE_FETCH;
            if (r_state == ST_UPPER) begin
                r_fetched <= d_fetched; r_alloc <= d_alloc; r_sel <= d_sel;
            end
            if (r_state == ST_WAIT) r_cnt <= '0;
            else if (r_state == ST_REQ && out_ok) r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_valid   = r_state == ST_RESP || r_state == ST_REQ;
    assign o_kind    = r_state == ST_REQ;
    assign o_fetched = r_state == ST_RESP && r_fetched;
    assign o_last    = (r_state == ST_RESP && !r_alloc)
                    || (r_state == ST_REQ && int'(r_cnt) == DEPTH - 1);

endmodule

`default_nettype wire

### rtl/instruction_stream_buffer_prefetch_core.sv
// a fill return is written as it is taken in ST_IDLE. a fetch or probe passes
// the lookup (ST_LOOK) and upper-half (ST_UPPER) states before its response
// (ST_RESP), then any DEPTH read requests follow the ST_WAIT setup state, one
// per cycle while i_stall is low. items are taken one at a time (o_stall).
// reset is synchronous active low and frees all streams and filled bits.
`default_nettype none

module instruction_stream_buffer_prefetch_core #(
    parameter int DEPTH       = 16,
    parameter int NUM_STREAMS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_addr,
    input  wire logic [31:0] i_fill_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic             o_fetched,
    output logic [31:0]      o_inst,
    output logic [63:0]      o_req_addr,
    output logic             o_last
);
    import isbp_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic        alloc_sel, kind, fetched;
    logic [31:0] inst;
    logic [63:0] req;

    isbp_datapath #(.DEPTH(DEPTH), .NUM_STREAMS(NUM_STREAMS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_alloc_sel(alloc_sel), .i_mode,
        .i_addr, .i_fill_word, .o_stat(stat), .o_inst(inst), .o_req_addr(req)
    );

    isbp_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_stat(stat),
        .o_cmd(cmd), .o_alloc_sel(alloc_sel), .o_valid, .i_stall,
        .o_kind(kind), .o_fetched(fetched), .o_last
    );

    assign o_kind     = kind;
    assign o_fetched  = fetched;
    assign o_inst     = fetched ? inst : 32'd0;
    assign o_req_addr = kind ? req : 64'd0;

endmodule

`default_nettype wire

### sim/instruction_stream_buffer_prefetch_core_tb.sv
// ----------------------------------------------------------------------------
// instruction_stream_buffer_prefetch_core_tb
// drives fetch, probe and fill-return transfers into the stream buffer
// prefetcher and checks every response and read request against a local
// model of the stream buffers kept in a small scoreboard class
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_stream_buffer_prefetch_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import isbp_pkg::*;

    localparam int DEPTH   = 16;
    localparam int NSTR    = 4;
    localparam int LIMIT   = 20000;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    typedef struct packed {
        logic        kind;
        logic        fetched;
        logic [31:0] inst;
        logic [63:0] req_addr;
        logic        last;
    } t_res;

    int errors = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    class prefetch_scoreboard;
        logic [63:0] base [NSTR];
        bit          live [NSTR];
        logic [31:0] word [NSTR*DEPTH];
        bit          full [NSTR*DEPTH];
        int          rptr;
        t_res        pending [$];

        function new();
            for (int s = 0; s < NSTR; s++) begin
                base[s] = '0;
                live[s] = 0;
            end
            for (int i = 0; i < NSTR*DEPTH; i++) begin
                word[i] = '0;
                full[i] = 0;
            end
            rptr = 0;
        endfunction

        function int find_stream(logic [63:0] a);
            logic [63:0] d;
            for (int s = 0; s < NSTR; s++) begin
                d = a - base[s];
                if (live[s] && d < 64'(DEPTH*4)) return s;
            end
            return -1;
        endfunction

        function void push(bit k, bit f, logic [31:0] ins, logic [63:0] ra);
            t_res r;
            r = '{kind: k, fetched: f, inst: ins, req_addr: ra, last: 1'b0};
            pending = {pending, r};
        endfunction

        function void open_stream(logic [63:0] a);
            logic [63:0] b;
            int s;
            b = a & WORD_MASK;
            s = -1;
            for (int t = 0; t < NSTR; t++)
                if (!live[t] && s < 0) s = t;
            if (s < 0) begin
                s = rptr;
                rptr = (rptr + 1) % NSTR;
            end
            base[s] = b;
            live[s] = 1;
            for (int y = 0; y < DEPTH; y++) begin
                full[s*DEPTH+y] = 0;
                push(1, 0, '0, b + 64'(y*4));
            end
        endfunction

        function void lookup(logic [63:0] addr, bit consume);
            logic [63:0] a, ua, nxt;
            int s, u, off, uoff;
            logic [31:0] ins;
            a = addr & ~64'd1;
            s = find_stream(a);
            if (s < 0) begin
                push(0, 0, '0, '0);
                open_stream(a);
                return;
            end
            off = int'((a - base[s]) >> 2);
            if (!full[s*DEPTH+off]) begin
                push(0, 0, '0, '0);
                return;
            end
            if (a[1] == 1'b0) begin
                ins = word[s*DEPTH+off];
            end else begin
                ua = a + 64'd2;
                u = find_stream(ua);
                if (u < 0) begin
                    push(0, 0, '0, '0);
                    open_stream(ua);
                    return;
                end
                uoff = int'((ua - base[u]) >> 2);
                if (!full[u*DEPTH+uoff]) begin
                    push(0, 0, '0, '0);
                    return;
                end
                ins = {word[u*DEPTH+uoff][15:0], word[s*DEPTH+off][31:16]};
            end
            push(0, 1, ins, '0);
            if (consume && off == DEPTH-1) begin
                nxt = base[s] + 64'(DEPTH*4);
                live[s] = 0;
                if (find_stream(nxt) < 0) open_stream(nxt);
            end
        endfunction

        // note an accepted input transfer
        function void note_input(logic [1:0] mode, logic [63:0] addr, logic [31:0] fw);
            int s;
            if (mode == MODE_FETCH || mode == MODE_PROBE) begin
                lookup(addr, mode == MODE_FETCH);
                pending[pending.size()-1].last = 1'b1;
            end else if (mode == MODE_FILL) begin
                s = find_stream(addr);
                if (s >= 0) begin
                    word[s*DEPTH + int'((addr - base[s]) >> 2)] = fw;
                    full[s*DEPTH + int'((addr - base[s]) >> 2)] = 1;
                end
            end
        endfunction

        task check_result(t_res got);
            t_res exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
                report($sformatf("kind %b exp %b", got.kind, exp.kind));
            if (got.fetched !== exp.fetched)
                report($sformatf("fetched %b exp %b", got.fetched, exp.fetched));
            if (got.inst !== exp.inst)
                report($sformatf("inst %h exp %h", got.inst, exp.inst));
            if (got.req_addr !== exp.req_addr)
                report($sformatf("req_addr %h exp %h", got.req_addr, exp.req_addr));
            if (got.last !== exp.last)
                report($sformatf("last %b exp %b", got.last, exp.last));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  in_mode = MODE_FETCH;
    logic [63:0] in_addr = '0;
    logic [31:0] in_fill = '0;
    logic        out_stall = 0;
    logic        out_valid, out_kind, out_fetched, out_last;
    logic [31:0] out_inst;
    logic [63:0] out_req;

    prefetch_scoreboard sb = new();

    bit hold_long = 0;   // request a long receiver hold-off
    bit calm = 0;        // no idling in the last part
    int idle_cycles = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    instruction_stream_buffer_prefetch_core #(.DEPTH(DEPTH), .NUM_STREAMS(NSTR)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_addr(in_addr), .i_fill_word(in_fill),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_kind(out_kind), .o_fetched(out_fetched), .o_inst(out_inst),
        .o_req_addr(out_req), .o_last(out_last)
    );

    // result check and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result('{kind: out_kind, fetched: out_fetched, inst: out_inst,
                                  req_addr: out_req, last: out_last});
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stall pattern
    initial begin
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_long) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                out_stall <= 0;
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
                @(posedge clk);
            end else begin
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic [1:0] mode, input logic [63:0] addr, input logic [31:0] fw);
        in_valid <= 1;
        in_mode  <= mode;
        in_addr  <= addr;
        in_fill  <= fw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(mode, addr, fw);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    // fill a whole stream window at base b, random words, shuffled order
    task automatic fill_window(input logic [63:0] b);
        int order [DEPTH];
        int j, t;
        for (int i = 0; i < DEPTH; i++) order[i] = i;
        for (int i = DEPTH-1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i < DEPTH; i++)
            send(MODE_FILL, b + 64'(order[i]*4), $urandom);
    endtask

    logic [63:0] region;

    initial begin
        logic [63:0] b, a;
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: miss, stall, fill, aligned and odd-halfword fetch, bit 0
        send(MODE_FETCH, 64'h1000, '0);
        send(MODE_FETCH, 64'h1004, '0);
        send(MODE_FILL, 64'h1000, 32'hFFFF_FFFF);
        send(MODE_FILL, 64'h1004, 32'h0000_0000);
        send(MODE_FILL, 64'h9999_0000, 32'h1234_5678);
        send(MODE_PROBE, 64'h1000, '0);
        send(MODE_FETCH, 64'h1001, '0);
        send(MODE_FETCH, 64'h1002, '0);
        send(MODE_FETCH, 64'h1006, '0);
        send(MODE_UNDEF, 64'h1000, '0);
        // upper half in a missing stream, then across the window end
        send(MODE_FILL, 64'h103C, 32'hA5A5_5A5A);
        send(MODE_FETCH, 64'h103E, '0);
        send(MODE_FETCH, 64'h103E, '0);
        send(MODE_FILL, 64'h1040, 32'h5A5A_A5A5);
        send(MODE_FETCH, 64'h103E, '0);
        // last slot consumed, next block already covered
        send(MODE_PROBE, 64'h103C, '0);
        send(MODE_FETCH, 64'h103C, '0);
        // window wrap at top of address space
        send(MODE_FETCH, 64'hFFFF_FFFF_FFFF_FFF8, '0);
        send(MODE_FILL, 64'hFFFF_FFFF_FFFF_FFFC, 32'hDEAD_BEEF);
        send(MODE_FILL, 64'h0000_0000_0000_0000, 32'hCAFE_F00D);
        send(MODE_FETCH, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        // replacement when all streams busy
        send(MODE_FETCH, 64'h8000_0000_0000_0000, '0);
        send(MODE_FETCH, 64'h0000_7FFF_FFFF_0000, '0);
        drain();

        // sender waits for every expected result
        send(MODE_PROBE, 64'h2000, '0);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_long = 1;
        for (int i = 0; i < 8; i++) send(MODE_PROBE, 64'(i) << 12, '0);
        drain();

        // random: mostly well-formed stream walks, with noise
        for (int k = 0; k < 7; k++) begin
            if (k == 5) calm = 1;
            region = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) region = 64'($urandom_range(0, 15)) << 6;
            b = region & WORD_MASK;
            send(MODE_FETCH, b, '0);
            fill_window(b);
            if ($urandom_range(0, 1)) fill_window(b + 64'(DEPTH*4));
            for (int i = 0; i < 6; i++) begin
                pick = $urandom_range(0, 9);
                a = b + 64'($urandom_range(0, 2*DEPTH-1) * 2);
                if (pick < 6) send(MODE_FETCH, a | 64'($urandom_range(0, 1)), '0);
                else if (pick < 8) send(MODE_PROBE, a, '0);
                else if (pick < 9) send(MODE_FILL, {$urandom, $urandom}, $urandom);
                else send(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
            end
            send(MODE_FETCH, b + 64'((DEPTH-1)*4), '0);
        end
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/isbp_pkg.sv
rtl/isbp_datapath.sv
rtl/isbp_ctrl.sv
rtl/instruction_stream_buffer_prefetch_core.sv
sim/instruction_stream_buffer_prefetch_core_tb.sv
